>>> rtl/core/frk_pkg.sv
// Shared widths, constants, types and helper functions of the Forest-Ruth step block.
package frk_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC      = 24;
    localparam int CFG_W     = 31;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int RND_W     = PROD_W - FRAC;
    localparam int SUM_W     = RND_W + 2;
    localparam int COEF_FRAC = 30;
    localparam int DVD_W     = CFG_W + FRAC;

    localparam logic [CFG_W-1:0] DT_RESET = CFG_W'(1677722);
    localparam logic [CFG_W-1:0] GM_RESET = CFG_W'(16777216);

    localparam logic [CFG_W-1:0] C_HALF_THETA     = CFG_W'(725423837);
    localparam logic [CFG_W-1:0] C_THETA          = CFG_W'(1450847675);
    localparam logic [CFG_W-1:0] C_HALF_ONE_MINUS = CFG_W'(188552925);
    localparam logic [CFG_W-1:0] C_ONE_MINUS_TWO  = CFG_W'(1827953526);

    localparam logic [0:0] CFG_TIME_STEP  = 1'b0;
    localparam logic [0:0] CFG_GRAV_PARAM = 1'b1;

    localparam logic signed [WORD_W-1:0] QMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] QMIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_stat;

    typedef struct packed {
        logic signed [WORD_W-1:0] val;
        logic                     ovf;
    } t_sat;

    // Coefficient magnitudes in Q.30; entries two and three are negative.
    function automatic logic [CFG_W-1:0] coef_mag(input logic [1:0] k);
        logic [CFG_W-1:0] c;
        unique case (k)
            2'd0:    c = C_HALF_THETA;
            2'd1:    c = C_THETA;
            2'd2:    c = C_HALF_ONE_MINUS;
            default: c = C_ONE_MINUS_TWO;
        endcase
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] x);
        logic [WORD_W-1:0] m;
        m = x[WORD_W-1] ? (~x + 1'b1) : x;
        return m;
    endfunction

    // Adds or subtracts a rounded magnitude to a word and clamps to the word range.
    function automatic t_sat sat_add(input logic signed [WORD_W-1:0] base,
                                     input logic [RND_W-1:0] m, input logic neg);
        logic signed [SUM_W-1:0] ext;
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] s;
        t_sat r;
        ext = {{(SUM_W-WORD_W){base[WORD_W-1]}}, base};
        t   = {2'b00, m};
        s   = neg ? (ext - t) : (ext + t);
        r.ovf = (s[SUM_W-1:WORD_W-1] != {(SUM_W-WORD_W+1){1'b0}}) &&
                (s[SUM_W-1:WORD_W-1] != {(SUM_W-WORD_W+1){1'b1}});
        r.val = r.ovf ? (s[SUM_W-1] ? QMIN : QMAX) : s[WORD_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/core/forest_ruth_kepler_step.sv
// Top level: one Forest-Ruth step of a body about a fixed centre, on shared units.
//
// A request on the input channel (i_in_valid, o_in_stall) either loads position
// and velocity (i_mode = 1) or advances them by one fourth-order step (i_mode = 0).
// Every request yields exactly one result on the output channel (o_out_valid,
// i_out_stall): the new state and a fault flag.
// A load passes straight to the result. A step first forms the four substep
// lengths, then runs four drifts and three kicks; each kick with a nonzero radius
// uses the iterative units, a square root and three divisions, plus the shared multiplier.
// The block holds one request at a time; o_in_stall is high from acceptance until
// the result has been written into the output register.
// The output register parts the sides: when the receiver stalls, a finished result
// waits there and the next result waits inside the block until the slot frees.
// Reset clears position and velocity to zero, restores dt = 0.1 and GM = 1.0,
// and drops any result in flight.
// Configuration writes through i_cfg_we take effect at once and belong to idle time.
module forest_ruth_kepler_step (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [0:0]                           i_cfg_index,
    input  logic [frk_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_mode,
    input  logic signed [frk_pkg::WORD_W-1:0]    i_load_pos_x,
    input  logic signed [frk_pkg::WORD_W-1:0]    i_load_pos_y,
    input  logic signed [frk_pkg::WORD_W-1:0]    i_load_pos_z,
    input  logic signed [frk_pkg::WORD_W-1:0]    i_load_vel_x,
    input  logic signed [frk_pkg::WORD_W-1:0]    i_load_vel_y,
    input  logic signed [frk_pkg::WORD_W-1:0]    i_load_vel_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [frk_pkg::WORD_W-1:0]    o_pos_x,
    output logic signed [frk_pkg::WORD_W-1:0]    o_pos_y,
    output logic signed [frk_pkg::WORD_W-1:0]    o_pos_z,
    output logic signed [frk_pkg::WORD_W-1:0]    o_vel_x,
    output logic signed [frk_pkg::WORD_W-1:0]    o_vel_y,
    output logic signed [frk_pkg::WORD_W-1:0]    o_vel_z,
    output logic                                 o_fault
);

    typedef enum logic [3:0] {
        S_IDLE, S_HMUL, S_HADD, S_DMUL, S_DADD, S_SMUL, S_SADD, S_QGO, S_QWAIT,
        S_VGO, S_VWAIT, S_AMUL, S_AADD, S_KMUL, S_KADD, S_DONE
    } t_state;

    t_state                          r_state;
    logic [2:0]                      r_phase;
    logic [1:0]                      r_idx;
    logic [1:0]                      r_divk;
    logic [frk_pkg::CFG_W-1:0]       r_dt;
    logic [frk_pkg::CFG_W-1:0]       r_gm;
    logic [frk_pkg::WORD_W-1:0]      r_hmag [4];
    logic signed [frk_pkg::WORD_W-1:0] r_pos [3];
    logic signed [frk_pkg::WORD_W-1:0] r_vel [3];
    logic [frk_pkg::PROD_W-1:0]      r_sum;
    logic [frk_pkg::WORD_W-1:0]      r_n;
    logic [frk_pkg::CFG_W-1:0]       r_w;
    logic signed [frk_pkg::WORD_W-1:0] r_acc;
    logic                            r_flt;
    logic                            r_out_valid;

    logic                            in_acc;
    logic [1:0]                      hsel;
    logic                            hneg;
    logic [frk_pkg::WORD_W-1:0]      hcur;
    logic [frk_pkg::WORD_W-1:0]      mul_a;
    logic [frk_pkg::WORD_W-1:0]      mul_b;
    logic [frk_pkg::PROD_W-1:0]      mul_p;
    logic [frk_pkg::PROD_W-1:0]      hp;
    logic [frk_pkg::PROD_W-1:0]      rp;
    logic [frk_pkg::RND_W-1:0]       rnd;
    logic [frk_pkg::PROD_W-1:0]      n_sum;
    frk_pkg::t_sat                   sres;
    t_state                          end_state;
    logic                            sq_done;
    logic [frk_pkg::WORD_W-1:0]      sq_root;
    frk_pkg::t_div_stat              div_st;
    logic [frk_pkg::CFG_W-1:0]       div_q;
    logic [frk_pkg::CFG_W-1:0]       div_x;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Substep selection: drifts use theta/2 and (1-theta)/2, kicks theta and 1-2theta.
    always_comb begin
        case (r_phase)
            3'd0, 3'd6: hsel = 2'd0;
            3'd1, 3'd5: hsel = 2'd1;
            3'd2, 3'd4: hsel = 2'd2;
            default:    hsel = 2'd3;
        endcase
        hneg = hsel[1];
        hcur = r_hmag[hsel];
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_HMUL: begin
                mul_a = {1'b0, r_dt};
                mul_b = {1'b0, frk_pkg::coef_mag(r_idx)};
            end
            S_DMUL: begin
                mul_a = frk_pkg::mag(r_vel[r_idx]);
                mul_b = hcur;
            end
            S_SMUL: begin
                mul_a = frk_pkg::mag(r_pos[r_idx]);
                mul_b = frk_pkg::mag(r_pos[r_idx]);
            end
            S_AMUL: begin
                mul_a = frk_pkg::mag(r_pos[r_idx]);
                mul_b = {1'b0, r_w};
            end
            S_KMUL: begin
                mul_a = frk_pkg::mag(r_acc);
                mul_b = hcur;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        hp    = mul_p + (frk_pkg::PROD_W'(1) << (frk_pkg::COEF_FRAC - 1));
        rp    = mul_p + (frk_pkg::PROD_W'(1) << (frk_pkg::FRAC - 1));
        rnd   = rp[frk_pkg::PROD_W-1:frk_pkg::FRAC];
        n_sum = r_sum + mul_p;
        div_x = (r_divk == 2'd0) ? r_gm : r_w;
        // The same saturating adder serves the drift, acceleration and kick updates.
        case (r_state)
            S_DADD:  sres = frk_pkg::sat_add(r_pos[r_idx], rnd,
                                             r_vel[r_idx][frk_pkg::WORD_W-1] ^ hneg);
            S_AADD:  sres = frk_pkg::sat_add('0, rnd, !r_pos[r_idx][frk_pkg::WORD_W-1]);
            default: sres = frk_pkg::sat_add(r_vel[r_idx], rnd,
                                             r_acc[frk_pkg::WORD_W-1] ^ hneg);
        endcase
        // After the last drift the step is done; drifts are followed by kicks.
        if (r_phase == 3'd6) begin
            end_state = S_DONE;
        end else if (!r_phase[0]) begin
            end_state = S_SMUL;
        end else begin
            end_state = S_DMUL;
        end
    end

    frk_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    frk_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_QGO),
        .i_v     (r_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    frk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_VGO),
        .i_x     (div_x),
        .i_n     (r_n),
        .o_stat  (div_st),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dt        <= frk_pkg::DT_RESET;
            r_gm        <= frk_pkg::GM_RESET;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    frk_pkg::CFG_TIME_STEP:  r_dt <= i_cfg_data;
                    frk_pkg::CFG_GRAV_PARAM: r_gm <= i_cfg_data;
                    default:                 r_gm <= r_gm;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_flt <= 1'b0;
                        r_idx <= 2'd0;
                        if (i_mode) begin
                            r_pos[0] <= i_load_pos_x;
                            r_pos[1] <= i_load_pos_y;
                            r_pos[2] <= i_load_pos_z;
                            r_vel[0] <= i_load_vel_x;
                            r_vel[1] <= i_load_vel_y;
                            r_vel[2] <= i_load_vel_z;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_HMUL;
                        end
                    end
                end
                S_HMUL: r_state <= S_HADD;
                S_HADD: begin
                    r_hmag[r_idx] <= hp[frk_pkg::COEF_FRAC+frk_pkg::WORD_W-1:frk_pkg::COEF_FRAC];
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == 2'd3) begin
                        r_phase <= 3'd0;
                        r_state <= S_DMUL;
                    end else begin
                        r_state <= S_HMUL;
                    end
                end
                S_DMUL: r_state <= S_DADD;
                S_DADD: begin
                    r_pos[r_idx] <= sres.val;
                    r_flt        <= r_flt | sres.ovf;
                    if (r_idx == 2'd2) begin
                        r_idx   <= 2'd0;
                        r_sum   <= '0;
                        r_phase <= r_phase + 1'b1;
                        r_state <= end_state;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_DMUL;
                    end
                end
                S_SMUL: r_state <= S_SADD;
                S_SADD: begin
                    r_sum <= n_sum;
                    if (r_idx == 2'd2) begin
                        r_idx <= 2'd0;
                        if (n_sum == '0) begin
                            // The body sits at the centre: no kick, flag a fault.
                            r_flt   <= 1'b1;
                            r_phase <= r_phase + 1'b1;
                            r_state <= end_state;
                        end else begin
                            r_state <= S_QGO;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SMUL;
                    end
                end
                S_QGO: r_state <= S_QWAIT;
                S_QWAIT: begin
                    if (sq_done) begin
                        r_n     <= sq_root;
                        r_divk  <= 2'd0;
                        r_state <= S_VGO;
                    end
                end
                S_VGO: r_state <= S_VWAIT;
                S_VWAIT: begin
                    if (div_st.done) begin
                        r_w   <= div_q;
                        r_flt <= r_flt | div_st.sat;
                        if (r_divk == 2'd2) begin
                            r_state <= S_AMUL;
                        end else begin
                            r_divk  <= r_divk + 1'b1;
                            r_state <= S_VGO;
                        end
                    end
                end
                S_AMUL: r_state <= S_AADD;
                S_AADD: begin
                    r_acc   <= sres.val;
                    r_flt   <= r_flt | sres.ovf;
                    r_state <= S_KMUL;
                end
                S_KMUL: r_state <= S_KADD;
                S_KADD: begin
                    r_vel[r_idx] <= sres.val;
                    r_flt        <= r_flt | sres.ovf;
                    if (r_idx == 2'd2) begin
                        r_idx   <= 2'd0;
                        r_phase <= r_phase + 1'b1;
                        r_state <= end_state;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_AMUL;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        o_pos_x     <= r_pos[0];
                        o_pos_y     <= r_pos[1];
                        o_pos_z     <= r_pos[2];
                        o_vel_x     <= r_vel[0];
                        o_vel_y     <= r_vel[1];
                        o_vel_z     <= r_vel[2];
                        o_fault     <= r_flt;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input accepted but block not busy next cycle");

    a_sqrt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QWAIT) && sq_done |-> (r_sum != '0))
        else $error("square root taken of a zero radius");

    a_div_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done && div_st.sat |-> (div_q == {frk_pkg::CFG_W{1'b1}}))
        else $error("saturated quotient is not the word maximum");
`endif

endmodule

>>> rtl/core/frk_mul.sv
// Shared registered unsigned multiplier of word magnitudes.
module frk_mul (
    input  logic                          i_clk,
    input  logic [frk_pkg::WORD_W-1:0]    i_a,
    input  logic [frk_pkg::WORD_W-1:0]    i_b,
    output logic [frk_pkg::PROD_W-1:0]    o_p
);

    logic [frk_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= frk_pkg::PROD_W'(i_a) * frk_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/frk_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
module frk_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [frk_pkg::PROD_W-1:0]    i_v,
    output logic                          o_done,
    output logic [frk_pkg::WORD_W-1:0]    o_root
);

    logic [frk_pkg::PROD_W-1:0] r_rad;
    logic [frk_pkg::WORD_W+3:0] r_rem;
    logic [frk_pkg::WORD_W-1:0] r_root;
    logic [4:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [frk_pkg::WORD_W+3:0] rem_sh;
    logic [frk_pkg::WORD_W+3:0] trial;

    always_comb begin
        rem_sh = {r_rem[frk_pkg::WORD_W+1:0], r_rad[frk_pkg::PROD_W-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_v;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 5'(frk_pkg::WORD_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[frk_pkg::WORD_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[frk_pkg::WORD_W-2:0], 1'b0};
                end
                r_rad <= {r_rad[frk_pkg::PROD_W-3:0], 2'b00};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> rtl/core/frk_div.sv
// Iterative restoring divider of a Q value by the radius, saturating at the word maximum.
module frk_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [frk_pkg::CFG_W-1:0]     i_x,
    input  logic [frk_pkg::WORD_W-1:0]    i_n,
    output frk_pkg::t_div_stat            o_stat,
    output logic [frk_pkg::CFG_W-1:0]     o_q
);

    localparam int LOW_W = frk_pkg::WORD_W - 1;
    localparam int HI_W  = frk_pkg::DVD_W - LOW_W;

    logic [frk_pkg::DVD_W-1:0]  dvd;
    logic [frk_pkg::WORD_W-1:0] hi;
    logic [frk_pkg::WORD_W:0]   sh;
    logic [frk_pkg::WORD_W-1:0] r_rem;
    logic [frk_pkg::WORD_W-1:0] r_den;
    logic [LOW_W-1:0]           r_low;
    logic [frk_pkg::CFG_W-1:0]  r_q;
    logic [4:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic                       r_sat;

    always_comb begin
        dvd = {i_x, {frk_pkg::FRAC{1'b0}}};
        hi  = frk_pkg::WORD_W'(dvd[frk_pkg::DVD_W-1 -: HI_W]);
        sh  = {r_rem, r_low[LOW_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_n;
                if (hi >= i_n) begin
                    // Quotient would reach 2^31: clamp without iterating.
                    r_q    <= '1;
                    r_sat  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= hi;
                    r_low  <= dvd[LOW_W-1:0];
                    r_q    <= '0;
                    r_sat  <= 1'b0;
                    r_cnt  <= 5'(LOW_W - 1);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (sh >= {1'b0, r_den}) begin
                    r_rem <= frk_pkg::WORD_W'(sh - {1'b0, r_den});
                    r_q   <= {r_q[frk_pkg::CFG_W-2:0], 1'b1};
                end else begin
                    r_rem <= sh[frk_pkg::WORD_W-1:0];
                    r_q   <= {r_q[frk_pkg::CFG_W-2:0], 1'b0};
                end
                r_low <= {r_low[LOW_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.sat  = r_sat;
    assign o_q         = r_q;

endmodule

>>> bench/forest_ruth_kepler_step_tb.sv
// Self-checking testbench of the Forest-Ruth orbit step block.
`timescale 1ns / 100ps

module forest_ruth_kepler_step_tb;

    localparam logic MODE_STEP = 1'b0;
    localparam logic MODE_LOAD = 1'b1;
    localparam int   CYCLE_LIMIT = 4_000_000;
    localparam int   MAX_SHOWN = 10;

    // Q.30 coefficient magnitudes of the four substeps.
    localparam longint unsigned K_HALF_THETA = 64'd725423837;
    localparam longint unsigned K_THETA      = 64'd1450847675;
    localparam longint unsigned K_HALF_ONE_M = 64'd188552925;
    localparam longint unsigned K_ONE_M_TWO  = 64'd1827953526;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [frk_pkg::WORD_W-1:0] pos [3];
        logic signed [frk_pkg::WORD_W-1:0] vel [3];
        logic                              fault;
    } t_orbit_state;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [0:0]                        i_cfg_index = frk_pkg::CFG_TIME_STEP;
    logic [frk_pkg::CFG_W-1:0]         i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic                              i_mode = MODE_STEP;
    logic signed [frk_pkg::WORD_W-1:0] i_load_pos_x = '0, i_load_pos_y = '0, i_load_pos_z = '0;
    logic signed [frk_pkg::WORD_W-1:0] i_load_vel_x = '0, i_load_vel_y = '0, i_load_vel_z = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic signed [frk_pkg::WORD_W-1:0] o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z;
    logic                              o_fault;

    forest_ruth_kepler_step dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor state: the body and the two registers, as the block should hold them.
    longint          body_pos [3];
    longint          body_vel [3];
    longint unsigned dt_q, gm_q;

    t_orbit_state state_q [$];
    int errors = 0;
    int results_seen = 0;
    int steps_sent = 0, loads_sent = 0, faults_seen = 0;
    int cycles = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;

    function automatic longint clamp_word(input longint v, inout bit flt);
        if (v > WORD_MAX) begin
            flt = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            flt = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    function automatic longint unsigned abs64(input longint a);
        return (a < 0) ? longint'(0) - a : a;
    endfunction

    // Q product, rounded half away from zero.
    function automatic longint qmul(input longint a, input longint b);
        longint unsigned p;
        p = abs64(a) * abs64(b);
        p = (p + (64'd1 << (frk_pkg::FRAC - 1))) >> frk_pkg::FRAC;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint substep_len(input longint unsigned k, input bit neg);
        longint unsigned p;
        p = (dt_q * k + (64'd1 << 29)) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned cap_word(input longint unsigned v, inout bit flt);
        if (v > longint'(WORD_MAX)) begin
            flt = 1'b1;
            return WORD_MAX;
        end
        return v;
    endfunction

    function automatic void drift(input longint h, inout bit flt);
        for (int i = 0; i < 3; i++)
            body_pos[i] = clamp_word(body_pos[i] + qmul(body_vel[i], h), flt);
    endfunction

    function automatic void kick(input longint h, inout bit flt);
        longint unsigned s, n, t, u, w;
        longint acc [3];
        s = 0;
        for (int i = 0; i < 3; i++) s += abs64(body_pos[i]) * abs64(body_pos[i]);
        if (s == 0) begin
            // Body at the centre: no pull, but the step is flagged.
            flt = 1'b1;
            return;
        end
        n = int_sqrt(s);
        t = cap_word((gm_q << frk_pkg::FRAC) / n, flt);
        u = cap_word((t << frk_pkg::FRAC) / n, flt);
        w = cap_word((u << frk_pkg::FRAC) / n, flt);
        for (int i = 0; i < 3; i++) acc[i] = clamp_word(-qmul(body_pos[i], longint'(w)), flt);
        for (int i = 0; i < 3; i++)
            body_vel[i] = clamp_word(body_vel[i] + qmul(acc[i], h), flt);
    endfunction

    // Applies one request to the predicted body and returns the state it reports.
    function automatic t_orbit_state advance_body(input logic mode,
                                    input logic signed [frk_pkg::WORD_W-1:0] lp [3],
                                    input logic signed [frk_pkg::WORD_W-1:0] lv [3]);
        t_orbit_state r;
        bit flt;
        longint h1, h2, h3, h4;
        flt = 1'b0;
        if (mode == MODE_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                body_pos[i] = lp[i];
                body_vel[i] = lv[i];
            end
        end else begin
            h1 = substep_len(K_HALF_THETA, 1'b0);
            h2 = substep_len(K_THETA, 1'b0);
            h3 = substep_len(K_HALF_ONE_M, 1'b1);
            h4 = substep_len(K_ONE_M_TWO, 1'b1);
            drift(h1, flt);
            kick(h2, flt);
            drift(h3, flt);
            kick(h4, flt);
            drift(h3, flt);
            kick(h2, flt);
            drift(h1, flt);
        end
        for (int i = 0; i < 3; i++) begin
            r.pos[i] = body_pos[i][frk_pkg::WORD_W-1:0];
            r.vel[i] = body_vel[i][frk_pkg::WORD_W-1:0];
        end
        r.fault = flt;
        return r;
    endfunction

    // Sends one request and records what it should produce once it is accepted.
    task automatic send_request(input logic mode,
                                input logic signed [frk_pkg::WORD_W-1:0] lp [3],
                                input logic signed [frk_pkg::WORD_W-1:0] lv [3]);
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_load_pos_x <= lp[0];
        i_load_pos_y <= lp[1];
        i_load_pos_z <= lp[2];
        i_load_vel_x <= lv[0];
        i_load_vel_y <= lv[1];
        i_load_vel_z <= lv[2];
        do @(posedge i_clk); while (o_in_stall);
        state_q.push_back(advance_body(mode, lp, lv));
        if (mode == MODE_LOAD) loads_sent++;
        else steps_sent++;
        // Random gaps between requests; valid stays high when there is none.
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        end
    endtask

    task automatic send_step();
        logic signed [frk_pkg::WORD_W-1:0] z [3];
        z = '{default: '0};
        send_request(MODE_STEP, z, z);
    endtask

    task automatic send_load(input logic signed [frk_pkg::WORD_W-1:0] px, py, pz, vx, vy, vz);
        logic signed [frk_pkg::WORD_W-1:0] lp [3];
        logic signed [frk_pkg::WORD_W-1:0] lv [3];
        lp = '{px, py, pz};
        lv = '{vx, vy, vz};
        send_request(MODE_LOAD, lp, lv);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (state_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [0:0] idx, input logic [frk_pkg::CFG_W-1:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == frk_pkg::CFG_TIME_STEP) dt_q = data;
        else gm_q = data;
    endtask

    task automatic set_rates(input longint unsigned dt, input longint unsigned gm);
        write_config(frk_pkg::CFG_TIME_STEP, dt[frk_pkg::CFG_W-1:0]);
        write_config(frk_pkg::CFG_GRAV_PARAM, gm[frk_pkg::CFG_W-1:0]);
    endtask

    // A coordinate near the unit orbit scale, or any word at all for noise.
    function automatic logic signed [frk_pkg::WORD_W-1:0] rand_coord(input bit wild,
                                                                     input int span);
        if (wild) return $urandom;
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    // Extreme and fixed loads, each echoed back unchanged and without a fault.
    task automatic test_loads();
        send_load(frk_pkg::QMAX, frk_pkg::QMIN, frk_pkg::QMAX,
                  frk_pkg::QMIN, frk_pkg::QMAX, frk_pkg::QMIN);
        send_load(frk_pkg::QMIN, frk_pkg::QMAX, frk_pkg::QMIN,
                  frk_pkg::QMAX, frk_pkg::QMIN, frk_pkg::QMAX);
        send_load(-1, -1, -1, -1, -1, -1);
        send_load(32'sh0100_0000, 0, 0, 0, 32'sh0100_0000, 0);
    endtask

    // Circular orbit at radius one, then a tilted orbit, stepped a few times.
    task automatic test_orbit();
        send_load(32'sh0100_0000, 0, 0, 0, 32'sh0100_0000, 0);
        repeat (4) send_step();
        send_load(-32'sh0200_0000, 32'sh0080_0000, 32'sh0040_0000,
                  32'sh0010_0000, -32'sh00A0_0000, 32'sh0030_0000);
        repeat (3) send_step();
    endtask

    // A body at the centre feels no pull but raises the fault flag.
    task automatic test_zero_radius();
        send_load(0, 0, 0, 0, 0, 0);
        send_step();
        send_load(0, 0, 0, 32'sh0100_0000, -32'sh0100_0000, 0);
        send_step();
    endtask

    // Large speeds and a close pass drive the sums and the divisions into clamping.
    task automatic test_saturation();
        send_load(frk_pkg::QMAX, 0, 0, frk_pkg::QMAX, frk_pkg::QMAX, frk_pkg::QMIN);
        send_step();
        send_load(1, 0, 0, 0, 0, 0);
        send_step();
        send_load(frk_pkg::QMIN, frk_pkg::QMIN, frk_pkg::QMIN,
                  frk_pkg::QMIN, frk_pkg::QMIN, frk_pkg::QMIN);
        send_step();
    endtask

    // Mostly well-formed runs: a load followed by up to five steps; some wild noise.
    task automatic test_random(input int count);
        int sent;
        int span;
        bit wild;
        sent = 0;
        while (sent < count) begin
            wild = ($urandom_range(99) < 15);
            span = ($urandom_range(3) == 0) ? 32'h7FFF_FFFF : 32'h0400_0000;
            send_load(rand_coord(wild, span), rand_coord(wild, span),
                      rand_coord(wild, span), rand_coord(wild, 32'h0200_0000),
                      rand_coord(wild, 32'h0200_0000), rand_coord(wild, 32'h0100_0000));
            sent++;
            repeat ($urandom_range(5)) begin
                if (sent < count) begin
                    send_step();
                    sent++;
                end
            end
            if ($urandom_range(99) < 2) drain();
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compares every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_orbit_state want;
        logic signed [frk_pkg::WORD_W-1:0] got_pos [3];
        logic signed [frk_pkg::WORD_W-1:0] got_vel [3];
        bit bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            got_pos = '{o_pos_x, o_pos_y, o_pos_z};
            got_vel = '{o_vel_x, o_vel_y, o_vel_z};
            if (o_fault) faults_seen++;
            if (state_q.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN) $display("ERROR: result with no request pending");
            end else begin
                want = state_q.pop_front();
                bad = (want.fault !== o_fault);
                for (int i = 0; i < 3; i++)
                    if (want.pos[i] !== got_pos[i] || want.vel[i] !== got_vel[i]) bad = 1'b1;
                if (bad) begin
                    errors++;
                    if (errors <= MAX_SHOWN) begin
                        $display("ERROR: result %0d exp pos %h %h %h vel %h %h %h f %b,",
                                 results_seen, want.pos[0], want.pos[1], want.pos[2],
                                 want.vel[0], want.vel[1], want.vel[2], want.fault);
                        $display("       got pos %h %h %h vel %h %h %h f %b",
                                 o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z,
                                 o_fault);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        // Predictor starts from the reset state of the block.
        dt_q = frk_pkg::DT_RESET;
        gm_q = frk_pkg::GM_RESET;
        for (int i = 0; i < 3; i++) begin
            body_pos[i] = 0;
            body_vel[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first with the reset rates; a step first checks the reset state.
        send_step();
        test_loads();
        test_orbit();
        test_zero_radius();
        set_rates(64'h7FFF_FFFF, 64'h7FFF_FFFF);
        test_saturation();
        set_rates(0, 0);
        test_orbit();

        // Random phases over several register settings and idling patterns.
        set_rates(frk_pkg::DT_RESET, frk_pkg::GM_RESET);
        test_random(500);
        sender_idle_pct = 78;
        set_rates(64'd167772, 64'd33554432);
        test_random(480);
        sender_idle_pct = 0;
        stall_pct = 78;
        set_rates(64'h7FFF_FFFF, 64'h7FFF_FFFF);
        test_random(300);
        sender_idle_pct = 15;
        stall_pct = 15;
        set_rates($urandom_range(32'h0800_0000), $urandom_range(32'h7FFF_FFFF));
        test_random(450);
        sender_idle_pct = 0;
        stall_pct = 0;
        set_rates(0, $urandom);
        test_random(200);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d steps and %0d loads, %0d results, %0d with fault set,",
                 steps_sent, loads_sent, results_seen, faults_seen);
        $display("over five register settings with sender gaps and receiver stalls.");
        if (errors == 0 && state_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> forest_ruth_kepler_step.f
rtl/core/frk_pkg.sv
rtl/core/frk_mul.sv
rtl/core/frk_isqrt.sv
rtl/core/frk_div.sv
rtl/core/forest_ruth_kepler_step.sv
bench/forest_ruth_kepler_step_tb.sv
